// ----- sv/plir_pkg.sv -----
// ----------------------------------------------------------------------------
// plir_pkg: shared types and constants for the positional list
// Item layouts, the per-cell control word, and action codes.
// ----------------------------------------------------------------------------
`default_nettype none

package plir_pkg;

  localparam int POS_W        = 7;
  localparam int DATA_W       = 32;
  localparam int LEN_W        = 7;
  localparam int CAPACITY_DEF = 64;
  localparam int GROUP_SZ     = 8;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } plir_in_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] removed_value;
    logic [LEN_W-1:0]         length;
  } plir_out_t;

  // Broadcast to every cell in the chain
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [POS_W-1:0]  pidx;   // zero-based target index
    logic [DATA_W-1:0] value;
  } plir_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/plir_cell.sv -----
// ----------------------------------------------------------------------------
// plir_cell: one list slot
// Holds one entry; on insert takes the left neighbor or the new value, on
// remove takes the right neighbor. Offers its entry when it is the target of a remove.
// ----------------------------------------------------------------------------
`default_nettype none

module plir_cell #(
  parameter int IDX = 0
) (
  input  wire                               clk,
  input  wire plir_pkg::plir_ctrl_t         ctrl,
  input  wire [plir_pkg::DATA_W-1:0]        left_q,
  input  wire [plir_pkg::DATA_W-1:0]        right_q,
  output logic [plir_pkg::DATA_W-1:0]       q,
  output logic [plir_pkg::DATA_W-1:0]       sel
);

  localparam logic [plir_pkg::POS_W-1:0] MY_IDX = plir_pkg::POS_W'(IDX);

  logic [plir_pkg::DATA_W-1:0] entry_r;
  logic [plir_pkg::DATA_W-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (MY_IDX > ctrl.pidx) begin
        entry_nxt = left_q;
      end else if (MY_IDX == ctrl.pidx) begin
        entry_nxt = ctrl.value;
      end
    end else if (ctrl.rem) begin
      if (MY_IDX >= ctrl.pidx) begin
        entry_nxt = right_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q   = entry_r;
  assign sel = (ctrl.rem && (MY_IDX == ctrl.pidx)) ? entry_r : '0;

endmodule

`default_nettype wire

// ----- sv/positional_list_insert_remove.sv -----
// ----------------------------------------------------------------------------
// positional_list_insert_remove: ordered list with positional insert/remove
// A row of CAPACITY cells, each shifting with its neighbors in the same cycle.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one operation item: insert value at a
//   1-based position, or remove the entry at a position. out_valid/out_ready/
//   out_data return one result item per operation: ok flag, removed value
//   (zero unless a remove succeeded) and list length after the operation.
//   After the accept the operation passes ST_REDUCE, and its result is valid in
//   ST_OUT. The list update happens in the accept cycle; the removed value is
//   picked by a two-level OR tree over the cells (groups of 8, registered):
//   the first level is registered in grp_r on the accept, the second in rv_r
//   in ST_REDUCE. No item is accepted in ST_REDUCE; a new item is accepted
//   in the same cycle that the previous result is taken.
//   Reset (rst_n low, synchronous) empties the list; entry contents are not
//   cleared, only the length. While the receiver stalls the result holds and
//   no new item is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_insert_remove #(
  parameter int CAPACITY = plir_pkg::CAPACITY_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire plir_pkg::plir_in_t in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output plir_pkg::plir_out_t   out_data
);

  localparam int GROUPS = (CAPACITY + plir_pkg::GROUP_SZ - 1) / plir_pkg::GROUP_SZ;
  localparam logic [plir_pkg::LEN_W-1:0] CAP_LEN = plir_pkg::LEN_W'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_OUT
  } state_t;

  state_t                      state_r;
  logic [plir_pkg::LEN_W-1:0]  cnt_r;
  logic [plir_pkg::LEN_W-1:0]  cnt_nxt;
  logic                        ok_r;
  logic [plir_pkg::DATA_W-1:0] rv_r;
  logic [plir_pkg::DATA_W-1:0] grp_r   [GROUPS];
  logic [plir_pkg::DATA_W-1:0] grp_nxt [GROUPS];
  logic [plir_pkg::DATA_W-1:0] rv_nxt;

  logic [plir_pkg::DATA_W-1:0] cell_q   [CAPACITY];
  logic [plir_pkg::DATA_W-1:0] cell_sel [CAPACITY];

  logic                        in_acc;
  logic                        pos_nz;
  logic [plir_pkg::LEN_W:0]    cnt_p1;
  logic                        ins_ok;
  logic                        rem_ok;
  plir_pkg::plir_ctrl_t        ctrl;

  assign in_ready = (state_r == ST_IDLE) || ((state_r == ST_OUT) && out_ready);
  assign in_acc   = in_valid && in_ready;

  assign pos_nz = (in_data.position != '0);
  assign cnt_p1 = {1'b0, cnt_r} + (plir_pkg::LEN_W+1)'(1);
  assign ins_ok = (in_data.action == plir_pkg::ACT_INSERT) && pos_nz &&
                  ({1'b0, in_data.position} <= cnt_p1) && (cnt_r < CAP_LEN);
  assign rem_ok = (in_data.action == plir_pkg::ACT_REMOVE) && pos_nz &&
                  (in_data.position <= cnt_r);

  always_comb begin
    ctrl.ins   = in_acc && ins_ok;
    ctrl.rem   = in_acc && rem_ok;
    ctrl.pidx  = in_data.position - plir_pkg::POS_W'(1);
    ctrl.value = in_data.value;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.ins) begin
      cnt_nxt = cnt_r + plir_pkg::LEN_W'(1);
    end else if (ctrl.rem) begin
      cnt_nxt = cnt_r - plir_pkg::LEN_W'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [plir_pkg::DATA_W-1:0] left_q;
    logic [plir_pkg::DATA_W-1:0] right_q;
    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_mid_l
      assign left_q = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_mid_r
      assign right_q = cell_q[i+1];
    end
    plir_cell #(
      .IDX(i)
    ) u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .left_q (left_q),
      .right_q(right_q),
      .q      (cell_q[i]),
      .sel    (cell_sel[i])
    );
  end

  // First OR level: at most one cell offers a nonzero word
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < plir_pkg::GROUP_SZ; k++) begin
        if (g * plir_pkg::GROUP_SZ + k < CAPACITY) begin
          grp_nxt[g] = grp_nxt[g] | cell_sel[g * plir_pkg::GROUP_SZ + k];
        end
      end
    end
  end

  always_comb begin
    rv_nxt = '0;
    for (int g = 0; g < GROUPS; g++) begin
      rv_nxt = rv_nxt | grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int g = 0; g < GROUPS; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ok_r    <= 1'b0;
      rv_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            ok_r    <= ins_ok || rem_ok;
            state_r <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          rv_r    <= rv_nxt;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (in_acc) begin
            ok_r    <= ins_ok || rem_ok;
            state_r <= ST_REDUCE;
          end else if (out_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid              = (state_r == ST_OUT);
  assign out_data.ok            = ok_r;
  assign out_data.removed_value = rv_r;
  assign out_data.length        = cnt_r;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for positional_list_insert_remove
// Builds insert/remove traffic, drives it through the input channel with
// random idling, keeps a shadow list to predict every result item, and checks
// ok, removed value and length of each item that comes back.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plir_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_ITEMS  = 700;
  localparam int CALM_TAIL   = 60;

  typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIX, MODE_NOISE} mix_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  plir_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  plir_out_t out_data;

  positional_list_insert_remove #(.CAPACITY(CAP)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow list and prediction
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] shadow_mem [CAP];
  int                       shadow_len = 0;
  plir_out_t                due_results [$];
  int                       errors = 0;

  function automatic plir_out_t step_list(plir_in_t op);
    plir_out_t res;
    int        p;
    int        i;
    res = '0;
    p   = int'(op.position);
    if (op.action == ACT_INSERT) begin
      if (p >= 1 && p <= shadow_len + 1 && shadow_len < CAP) begin
        for (i = shadow_len; i >= p; i--) shadow_mem[i] = shadow_mem[i-1];
        shadow_mem[p-1] = op.value;
        shadow_len++;
        res.ok = 1'b1;
      end
    end else begin
      if (p >= 1 && p <= shadow_len) begin
        res.removed_value = shadow_mem[p-1];
        for (i = p - 1; i + 1 < shadow_len; i++) shadow_mem[i] = shadow_mem[i+1];
        shadow_len--;
        res.ok = 1'b1;
      end
    end
    res.length = shadow_len[LEN_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building; gen_len tracks the list length as the items are queued
  // ---------------------------------------------------------------------------
  plir_in_t feed_q [$];
  int       gen_len     = 0;
  int       total_items = 0;
  int       fed         = 0;

  task automatic add_op(input logic act, input int pos, input logic [DATA_W-1:0] val);
    plir_in_t op;
    op.action   = act;
    op.position = pos[POS_W-1:0];
    op.value    = val;
    feed_q.push_back(op);
    if (act == ACT_INSERT) begin
      if (pos >= 1 && pos <= gen_len + 1 && gen_len < CAP) gen_len++;
    end else if (pos >= 1 && pos <= gen_len) begin
      gen_len--;
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_op(input mix_t mode);
    logic act;
    int   pos;
    int   lim;
    int   r;
    case (mode)
      MODE_GROW:   act = ($urandom_range(0, 99) < 85) ? ACT_INSERT : ACT_REMOVE;
      MODE_SHRINK: act = ($urandom_range(0, 99) < 85) ? ACT_REMOVE : ACT_INSERT;
      default:     act = $urandom_range(0, 1) ? ACT_REMOVE : ACT_INSERT;
    endcase
    if (mode == MODE_NOISE) begin
      pos = $urandom_range(0, 127);
    end else begin
      lim = (act == ACT_INSERT) ? gen_len + 1 : gen_len;
      r   = $urandom_range(0, 19);
      if (r == 0)
        pos = 0;
      else if (r == 1)
        pos = (lim + 1 > 127) ? 127 : lim + 1;
      else if (r == 2)
        pos = $urandom_range(0, 127);
      else if (r == 3)
        pos = (lim == 0) ? 1 : lim;
      else if (r == 4)
        pos = 1;
      else
        pos = (lim == 0) ? 1 : $urandom_range(1, lim);
    end
    add_op(act, pos, pick_value());
  endtask

  // ---------------------------------------------------------------------------
  // Idling control and run limit
  // ---------------------------------------------------------------------------
  int  cycles    = 0;
  int  idle_odds = 0;
  int  in_gap    = 0;
  int  out_gap   = 0;
  wire calm      = (total_items - fed) < CALM_TAIL;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    // idling density changes now and then, sometimes to none at all
    if (cycles % 150 == 0) idle_odds <= $urandom_range(0, 3);
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_gap != 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) < idle_odds) begin
        in_gap   <= $urandom_range(0, 2);
        in_valid <= 1'b0;
      end else if (feed_q.size() != 0) begin
        in_data  <= feed_q.pop_front();
        in_valid <= 1'b1;
        fed      <= fed + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap   <= 0;
    end else if (out_gap != 0) begin
      out_gap   <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) < idle_odds) begin
      out_gap   <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor
  always @(posedge clk) begin : monitor
    plir_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result item with nothing expected: ok=%0b removed_value=%0d length=%0d",
                 out_data.ok, out_data.removed_value, out_data.length);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (out_data.ok !== want.ok) begin
            $error("ok: expected %0b, got %0b", want.ok, out_data.ok);
            errors++;
          end
          if (out_data.removed_value !== want.removed_value) begin
            $error("removed_value: expected %0d, got %0d",
                   want.removed_value, out_data.removed_value);
            errors++;
          end
          if (out_data.length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, out_data.length);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) due_results.push_back(step_list(in_data));
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    int r;
    mix_t mode;

    // directed: empty list, bad positions, front/middle/end updates
    add_op(ACT_REMOVE, 1, 32'h0);
    add_op(ACT_INSERT, 0, 32'h1111_1111);
    add_op(ACT_INSERT, 2, 32'h2222_2222);
    add_op(ACT_REMOVE, 0, 32'h0);
    add_op(ACT_INSERT, 1, 32'h7FFF_FFFF);
    add_op(ACT_INSERT, 1, 32'h8000_0000);
    add_op(ACT_INSERT, 3, 32'hFFFF_FFFF);
    add_op(ACT_INSERT, 2, 32'h0000_0000);
    add_op(ACT_INSERT, 127, 32'h5555_5555);
    add_op(ACT_INSERT, 6, 32'h3333_3333);
    add_op(ACT_REMOVE, 5, 32'h0);
    add_op(ACT_REMOVE, 127, 32'hFFFF_FFFF);
    add_op(ACT_REMOVE, 0, 32'h0);
    add_op(ACT_INSERT, 5, 32'hAAAA_AAAA);
    add_op(ACT_REMOVE, 3, 32'h1234_5678);
    add_op(ACT_REMOVE, 1, 32'h0);
    add_op(ACT_REMOVE, 3, 32'h0);
    add_op(ACT_REMOVE, 1, 32'h0);
    add_op(ACT_REMOVE, 1, 32'h0);
    add_op(ACT_REMOVE, 1, 32'h0);

    // fill to capacity, then hit the full list
    while (gen_len < CAP) add_op(ACT_INSERT, $urandom_range(1, gen_len + 1), pick_value());
    add_op(ACT_INSERT, 1, pick_value());
    add_op(ACT_INSERT, CAP, pick_value());
    add_op(ACT_INSERT, CAP + 1, pick_value());
    add_op(ACT_INSERT, 127, pick_value());
    add_op(ACT_REMOVE, CAP, 32'h0);
    add_op(ACT_INSERT, CAP, pick_value());

    while (feed_q.size() < RAND_ITEMS + 20) begin
      r = $urandom_range(0, 9);
      if (r == 0)
        mode = MODE_NOISE;
      else if (r <= 3)
        mode = MODE_GROW;
      else if (r <= 6)
        mode = MODE_SHRINK;
      else
        mode = MODE_MIX;
      n = $urandom_range(20, 80);
      repeat (n) random_op(mode);
    end
    total_items = feed_q.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (feed_q.size() != 0 || in_valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
